// ===== src/twdt_pkg.sv =====
// twdt_pkg: shared types and constants for the time-window distinct table.
// Used by twdt_ctrl, twdt_dpath and time_distinct_window_table.
package twdt_pkg;

   localparam int TIME_W = 48;
   localparam int ID_W   = 10;
   localparam int CNT_W  = 11;

   localparam logic [TIME_W-1:0] WINDOW_RESET = 48'd1000;

   localparam logic CMD_PUSH    = 1'b0;
   localparam logic CMD_REFRESH = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // take a request word, start a new sweep
      logic clear_wr;  // clearing pass after reset
      logic scan_rd;   // issue a sweep read at the scan address
   } twdt_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last; // scan address sits on the last entry
   } twdt_stat_type;

endpackage

// ===== src/twdt_ctrl.sv =====
// twdt_ctrl: sequencer for clearing pass, table sweep and response strobe.
// Depends on twdt_pkg.
module twdt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  twdt_pkg::twdt_stat_type stat,
   output twdt_pkg::twdt_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import twdt_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SWEEP = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.scan_last) state_in = ST_IDLE;
         end
         ST_IDLE, ST_RESP: begin
            // a new word may enter while the last response is strobed
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_SWEEP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            cmd.scan_rd = 1'b1;
            if (stat.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = !(state_ff == ST_IDLE || state_ff == ST_RESP);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

// ===== src/twdt_dpath.sv =====
// twdt_dpath: entry memory, scan counter, expiry check and newest-entry search.
// Depends on twdt_pkg; driven by twdt_ctrl.
module twdt_dpath #(
   parameter int NUM_OBJECTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  twdt_pkg::twdt_cmd_type         cmd,
   output twdt_pkg::twdt_stat_type        stat,
   input  logic                          req_cmd,
   input  logic [twdt_pkg::ID_W-1:0]     req_obj_id,
   input  logic [twdt_pkg::TIME_W-1:0]   req_event_time,
   input  logic [twdt_pkg::TIME_W-1:0]   req_now,
   input  logic                          csr_valid,
   input  logic [twdt_pkg::TIME_W-1:0]   csr_window_len,
   output logic [twdt_pkg::CNT_W-1:0]    rsp_entry_count,
   output logic                          rsp_is_empty,
   output logic                          rsp_front_valid,
   output logic [twdt_pkg::ID_W-1:0]     rsp_front_id,
   output logic [twdt_pkg::TIME_W-1:0]   rsp_front_time
);
   import twdt_pkg::*;

   localparam int IDX_W = $clog2(NUM_OBJECTS);
   localparam int ENT_W = TIME_W + 1;   // {valid, time}
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_OBJECTS - 1);

   logic [ENT_W-1:0] mem [NUM_OBJECTS];

   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              rd_vld_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [ENT_W-1:0]  rd_data_ff;
   logic              mode_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] win_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_time_ff, best_time_in;

   logic              push_we;
   logic              ent_valid;
   logic [TIME_W-1:0] ent_time;
   logic              expired;
   logic              keep;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ENT_W-1:0]  wr_data;

   assign ent_valid = rd_data_ff[ENT_W-1];
   assign ent_time  = rd_data_ff[TIME_W-1:0];
   // 49-bit sum, never wraps
   assign expired   = (mode_ff == CMD_REFRESH) &&
                      (({1'b0, ent_time} + {1'b0, win_ff}) < {1'b0, now_ff});
   assign keep      = rd_vld_ff && ent_valid && !expired;

   assign push_we = cmd.capture && (req_cmd == CMD_PUSH) &&
                    (32'(req_obj_id) < 32'(NUM_OBJECTS));

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = scan_ff;
      wr_data = '0;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (push_we) begin
         wr_en   = 1'b1;
         wr_addr = IDX_W'(req_obj_id);
         wr_data = {1'b1, req_event_time};
      end else if (rd_vld_ff && ent_valid && expired) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff;
         wr_data = {1'b0, ent_time};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         rd_data_ff <= mem[scan_ff];
         rd_idx_ff  <= scan_ff;
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.capture) begin
         scan_in = '0;
      end else if (cmd.clear_wr || cmd.scan_rd) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   assign stat.scan_last = (scan_ff == LAST_IDX);

   // running count and newest entry; ascending scan with strict > keeps lowest id
   always_comb begin
      count_in     = count_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_time_in = best_time_ff;
      if (cmd.capture) begin
         count_in     = '0;
         found_in     = 1'b0;
         best_idx_in  = '0;
         best_time_in = '0;
      end else if (keep) begin
         count_in = count_ff + 1'b1;
         if (!found_ff || ent_time > best_time_ff) begin
            found_in     = 1'b1;
            best_idx_in  = rd_idx_ff;
            best_time_in = ent_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff   <= '0;
         rd_vld_ff <= 1'b0;
         win_ff    <= WINDOW_RESET;
         count_ff  <= '0;
         found_ff  <= 1'b0;
      end else begin
         scan_ff   <= scan_in;
         rd_vld_ff <= cmd.scan_rd;
         if (csr_valid) win_ff <= csr_window_len;
         count_ff  <= count_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      if (cmd.capture) begin
         mode_ff <= req_cmd;
         now_ff  <= req_now;
      end
   end

   assign rsp_entry_count = count_ff;
   assign rsp_is_empty    = (count_ff == '0);
   assign rsp_front_valid = found_ff;
   assign rsp_front_id    = ID_W'(best_idx_ff);
   assign rsp_front_time  = best_time_ff;

endmodule

// ===== src/time_distinct_window_table.sv =====
// time_distinct_window_table: top level, controller plus datapath.
// Depends on twdt_pkg, twdt_ctrl and twdt_dpath.
//
//   channel   handshake               word
//   request   start / busy            req_cmd, req_obj_id, req_event_time, req_now
//   response  rsp_valid (strobe)      rsp_entry_count .. rsp_front_time
//   config    csr_valid / csr_ready   csr_window_len
//
// Each word runs one sweep over the entry memory from accept to response strobe,
// one entry read per cycle on its single read port.
// A new word may be accepted in the cycle its predecessor's response is strobed.
// After reset a clearing pass over every entry runs with busy high.
// Responses are strobed for one cycle; the receiver cannot stall them.
module time_distinct_window_table #(
   parameter int NUM_OBJECTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic [twdt_pkg::ID_W-1:0]     req_obj_id,
   input  logic [twdt_pkg::TIME_W-1:0]   req_event_time,
   input  logic [twdt_pkg::TIME_W-1:0]   req_now,
   output logic                          rsp_valid,
   output logic [twdt_pkg::CNT_W-1:0]    rsp_entry_count,
   output logic                          rsp_is_empty,
   output logic                          rsp_front_valid,
   output logic [twdt_pkg::ID_W-1:0]     rsp_front_id,
   output logic [twdt_pkg::TIME_W-1:0]   rsp_front_time,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [twdt_pkg::TIME_W-1:0]   csr_window_len
);
   import twdt_pkg::*;

   twdt_cmd_type  cmd;
   twdt_stat_type stat;

   assign csr_ready = 1'b1;

   twdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   twdt_dpath #(
      .NUM_OBJECTS (NUM_OBJECTS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_cmd         (req_cmd),
      .req_obj_id      (req_obj_id),
      .req_event_time  (req_event_time),
      .req_now         (req_now),
      .csr_valid       (csr_valid && csr_ready),
      .csr_window_len  (csr_window_len),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_front_valid (rsp_front_valid),
      .rsp_front_id    (rsp_front_id),
      .rsp_front_time  (rsp_front_time)
   );

`ifndef NO_ASSERTIONS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_empty_front: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == !rsp_front_valid))
      else $error("empty flag disagrees with front entry");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.clear_wr, cmd.scan_rd}))
      else $error("controller issued overlapping commands");
`endif

endmodule

// ===== test/twdt_table_checker.sv =====
// twdt_table_checker: watches the request, response and window channels of
// time_distinct_window_table, predicts every response word and compares it.
// Depends on twdt_pkg.
`timescale 1ns / 100ps
module twdt_table_checker #(
   parameter int NUM_OBJECTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_cmd,
   input  logic [twdt_pkg::ID_W-1:0]     req_obj_id,
   input  logic [twdt_pkg::TIME_W-1:0]   req_event_time,
   input  logic [twdt_pkg::TIME_W-1:0]   req_now,
   input  logic                          rsp_valid,
   input  logic [twdt_pkg::CNT_W-1:0]    rsp_entry_count,
   input  logic                          rsp_is_empty,
   input  logic                          rsp_front_valid,
   input  logic [twdt_pkg::ID_W-1:0]     rsp_front_id,
   input  logic [twdt_pkg::TIME_W-1:0]   rsp_front_time,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [twdt_pkg::TIME_W-1:0]   csr_window_len,
   output int unsigned                   mismatch_count,
   output int unsigned                   words_waiting
);
   import twdt_pkg::*;

   typedef struct {
      logic [CNT_W-1:0]  entry_count;
      logic              is_empty;
      logic              front_valid;
      logic [ID_W-1:0]   front_id;
      logic [TIME_W-1:0] front_time;
   } table_report_type;

   logic              live [NUM_OBJECTS];
   logic [TIME_W-1:0] stamp [NUM_OBJECTS];
   int unsigned       held;
   logic [TIME_W-1:0] window_len;
   table_report_type  expected_reports [$];

   task automatic flag_error(input string msg);
      mismatch_count++;
      $display("%0t ns: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [63:0] seen,
         input logic [63:0] wanted);
      if (seen !== wanted)
         flag_error($sformatf("%s is %0h, expected %0h", name, seen, wanted));
   endtask

   // updates the table for one word and returns the report it should produce
   function automatic table_report_type apply_word(input logic cmd,
         input logic [ID_W-1:0] id, input logic [TIME_W-1:0] ev_time,
         input logic [TIME_W-1:0] now_time);
      table_report_type r;
      logic [TIME_W:0]  reach;
      int               i;
      r = '{default: '0};
      if (cmd == CMD_PUSH) begin
         if (int'(id) < NUM_OBJECTS) begin
            if (!live[id]) begin
               live[id] = 1'b1;
               held++;
            end
            stamp[id] = ev_time;
         end
      end else begin
         for (i = 0; i < NUM_OBJECTS; i++) begin
            if (live[i]) begin
               // 49-bit sum, no wrap
               reach = {1'b0, stamp[i]} + {1'b0, window_len};
               if (reach < {1'b0, now_time}) begin
                  live[i] = 1'b0;
                  if (held > 0)
                     held--;
               end
            end
         end
      end
      // strict compare keeps the lowest id on a tie
      for (i = 0; i < NUM_OBJECTS; i++) begin
         if (live[i] && (!r.front_valid || stamp[i] > r.front_time)) begin
            r.front_valid = 1'b1;
            r.front_id    = ID_W'(i);
            r.front_time  = stamp[i];
         end
      end
      r.entry_count = CNT_W'(held);
      r.is_empty    = (held == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      table_report_type want;
      table_report_type fresh;
      int               i;
      if (reset) begin
         for (i = 0; i < NUM_OBJECTS; i++)
            live[i] = 1'b0;
         held       = 0;
         window_len = WINDOW_RESET;
         expected_reports.delete();
         mismatch_count = 0;
      end else begin
         // retire the older word before a new one is queued in the same cycle
         if (rsp_valid === 1'b1) begin
            if (expected_reports.size() == 0) begin
               flag_error("response word with nothing outstanding");
            end else begin
               want = expected_reports.pop_front();
               compare_field("entry_count", 64'(rsp_entry_count), 64'(want.entry_count));
               compare_field("is_empty", 64'(rsp_is_empty), 64'(want.is_empty));
               compare_field("front_valid", 64'(rsp_front_valid), 64'(want.front_valid));
               compare_field("front_id", 64'(rsp_front_id), 64'(want.front_id));
               compare_field("front_time", 64'(rsp_front_time), 64'(want.front_time));
            end
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1)
            window_len = csr_window_len;
         if (start === 1'b1 && busy === 1'b0) begin
            fresh = apply_word(req_cmd, req_obj_id, req_event_time, req_now);
            expected_reports.insert(expected_reports.size(), fresh);
         end
      end
      words_waiting <= expected_reports.size();
   end

endmodule

// ===== test/time_distinct_window_table_tb.sv =====
// time_distinct_window_table_tb: drives push and refresh words and window writes
// into time_distinct_window_table; twdt_table_checker predicts and compares.
// Depends on twdt_pkg, twdt_table_checker and the block itself.
`timescale 1ns / 100ps
module time_distinct_window_table_tb;
   import twdt_pkg::*;

   localparam int NUM_OBJECTS = 1024;
   localparam int IDLE_LIMIT  = 5000;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 70;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              start          = 1'b0;
   logic              req_cmd        = CMD_PUSH;
   logic [ID_W-1:0]   req_obj_id     = '0;
   logic [TIME_W-1:0] req_event_time = '0;
   logic [TIME_W-1:0] req_now        = '0;
   logic              csr_valid      = 1'b0;
   logic [TIME_W-1:0] csr_window_len = '0;

   logic              busy;
   logic              rsp_valid;
   logic [CNT_W-1:0]  rsp_entry_count;
   logic              rsp_is_empty;
   logic              rsp_front_valid;
   logic [ID_W-1:0]   rsp_front_id;
   logic [TIME_W-1:0] rsp_front_time;
   logic              csr_ready;

   int unsigned       mismatch_count;
   int unsigned       words_waiting;
   int unsigned       push_words    = 0;
   int unsigned       refresh_words = 0;
   int unsigned       window_writes = 0;
   int unsigned       idle_cycles   = 0;
   bit                calm          = 1'b0;
   logic [TIME_W-1:0] window_now    = WINDOW_RESET;

   time_distinct_window_table #(.NUM_OBJECTS(NUM_OBJECTS)) u_top (.*);

   twdt_table_checker #(.NUM_OBJECTS(NUM_OBJECTS)) u_checker (.*);

   always #5 clock = ~clock;

   // watchdog: any handshake or response strobe counts as progress
   always @(posedge clock) begin
      if (reset || rsp_valid === 1'b1 || (start === 1'b1 && busy === 1'b0) ||
          (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("no progress for %0d cycles, %0d words outstanding", IDLE_LIMIT,
                  words_waiting);
         $display("time_distinct_window_table_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [TIME_W-1:0] rand48();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[TIME_W-1:0];
   endfunction

   // called at an edge; returns at the edge that accepts the word
   task automatic send_word(input logic cmd, input logic [ID_W-1:0] id,
         input logic [TIME_W-1:0] ev_time, input logic [TIME_W-1:0] now_time);
      int unsigned roll;
      int unsigned gap;
      roll = $urandom_range(0, 99);
      if (calm || roll < 45)
         gap = 0;
      else if (roll < 85)
         gap = $urandom_range(1, 4);
      else if (roll < 96)
         gap = $urandom_range(5, 24);
      else
         gap = $urandom_range(100, 600);
      if (gap != 0) begin
         // let the sweep finish, then idle before the next word
         start <= 1'b0;
         @(posedge clock);
         while (busy !== 1'b0)
            @(posedge clock);
         repeat (gap - 1) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_obj_id     <= id;
      req_event_time <= ev_time;
      req_now        <= now_time;
      if (cmd == CMD_PUSH)
         push_words++;
      else
         refresh_words++;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // window is only changed with the table idle and nothing outstanding
   task automatic write_window(input logic [TIME_W-1:0] value);
      start <= 1'b0;
      do @(posedge clock); while (words_waiting != 0 || busy !== 1'b0);
      csr_valid      <= 1'b1;
      csr_window_len <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid  <= 1'b0;
      window_now = value;
      window_writes++;
   endtask

   initial begin
      logic [TIME_W-1:0] cursor;
      logic [TIME_W-1:0] ev_time;
      logic [TIME_W-1:0] now_time;
      logic [TIME_W-1:0] w;
      logic [TIME_W+1:0] probe;
      logic [ID_W-1:0]   id;
      int unsigned       roll;
      int                p;
      int                k;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset window of 1000: empty table, ties, repeated ids, expiry edges
      send_word(CMD_REFRESH, '1, TIME_MAX, '0);
      send_word(CMD_PUSH, 10'd0, '0, TIME_MAX);
      send_word(CMD_PUSH, 10'd1023, TIME_MAX, '0);
      send_word(CMD_PUSH, 10'd5, TIME_MAX, rand48());
      send_word(CMD_PUSH, 10'd1023, 48'd100, rand48());
      send_word(CMD_PUSH, 10'd5, 48'd2000, rand48());
      send_word(CMD_REFRESH, 10'd0, '0, 48'd1000);
      send_word(CMD_REFRESH, 10'd0, '0, 48'd1001);
      send_word(CMD_REFRESH, 10'h2AA, TIME_MAX, 48'd3000);
      send_word(CMD_REFRESH, 10'h155, '0, 48'd3001);
      // widest window: sum exceeds 48 bits and must not wrap
      write_window(TIME_MAX);
      send_word(CMD_PUSH, 10'h2AA, TIME_MAX, '0);
      send_word(CMD_PUSH, 10'h155, TIME_MAX - 1, TIME_MAX);
      send_word(CMD_REFRESH, 10'd0, '0, TIME_MAX);
      // zero window: expiry exactly one tick past the stamp
      write_window('0);
      send_word(CMD_PUSH, 10'd7, 48'd50, '0);
      send_word(CMD_REFRESH, 10'd0, '0, 48'd50);
      send_word(CMD_REFRESH, 10'd0, '0, 48'd51);
      send_word(CMD_REFRESH, '1, TIME_MAX, TIME_MAX);
      send_word(CMD_PUSH, 10'h155, '0, TIME_MAX);
      send_word(CMD_PUSH, 10'h2AA, '0, '0);

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0:       w = TIME_W'($urandom_range(0, 50));
            1:       w = TIME_MAX;
            2:       w = '0;
            3:       w = rand48();
            4:       w = WINDOW_RESET;
            5:       w = TIME_W'($urandom_range(100, 5000));
            6:       w = rand48();
            default: w = TIME_W'($urandom_range(1, 200));
         endcase
         write_window(w);
         calm = (p % 3 == 1);
         if ($urandom_range(0, 3) == 0)
            cursor = rand48();
         else
            cursor = TIME_W'($urandom_range(0, 1 << 20));
         for (k = 0; k < PHASE_WORDS; k++) begin
            cursor = cursor + TIME_W'($urandom_range(0, 40));
            roll   = $urandom_range(0, 99);
            if (roll < 60) begin
               // mostly a small id pool so ids repeat and expire
               roll = $urandom_range(0, 9);
               if (roll < 6)
                  id = ID_W'($urandom_range(0, 23));
               else if (roll < 9)
                  id = ID_W'($urandom_range(0, 1023));
               else
                  id = $urandom_range(0, 1) ? '1 : '0;
               roll = $urandom_range(0, 9);
               if (roll < 8)
                  ev_time = cursor - TIME_W'($urandom_range(0, 64));
               else if (roll < 9)
                  ev_time = rand48();
               else
                  ev_time = $urandom_range(0, 1) ? TIME_MAX : '0;
               send_word(CMD_PUSH, id, ev_time, rand48());
            end else begin
               if ($urandom_range(0, 6) == 0) begin
                  now_time = rand48();
               end else begin
                  // land near the expiry boundary of recent stamps
                  probe = {2'b0, cursor} + {2'b0, window_now} +
                          (TIME_W+2)'($urandom_range(0, 40));
                  probe = (probe < 20) ? '0 : probe - 20;
                  now_time = (probe > {2'b0, TIME_MAX}) ? TIME_MAX : probe[TIME_W-1:0];
               end
               send_word(CMD_REFRESH, ID_W'($urandom_range(0, 1023)), rand48(), now_time);
            end
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (words_waiting != 0);
      repeat (NUM_OBJECTS + 16) @(posedge clock);
      $display("covered %0d pushes and %0d refreshes across %0d window writes",
               push_words, refresh_words, window_writes);
      if (mismatch_count == 0)
         $display("time_distinct_window_table_tb: done, clean");
      else
         $display("time_distinct_window_table_tb: done, errors");
      $finish;
   end

endmodule

// ===== time_distinct_window_table.f =====
src/twdt_pkg.sv
src/twdt_ctrl.sv
src/twdt_dpath.sv
src/time_distinct_window_table.sv
test/twdt_table_checker.sv
test/time_distinct_window_table_tb.sv
